// ----- hdl/ampf_pkg.sv -----
// Package for the ambiguous match pair filter: defaults and shared types.
package ampf_pkg;

	localparam int unsigned CAPACITY_DEF   = 64;
	localparam int unsigned COORD_BITS_DEF = 24;

	typedef struct packed {
		logic valid;
		logic mark;
	} ampf_flags_t;

	typedef struct packed {
		logic load;
		logic mark_new;
		logic shift;
	} ampf_ctrl_t;

endpackage

// ----- hdl/ampf_cell.sv -----
// One storage cell of the pair chain: holds a pair, compares and shifts toward the head.
module ampf_cell import ampf_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ampf_ctrl_t                ctrl,
	input  logic                      sel,
	input  logic [2*COORD_BITS-1:0]   new_fp,
	input  logic [2*COORD_BITS-1:0]   new_sp,
	input  ampf_flags_t               nxt_flags,
	input  logic [2*COORD_BITS-1:0]   nxt_fp,
	input  logic [2*COORD_BITS-1:0]   nxt_sp,
	output ampf_flags_t               flags,
	output logic [2*COORD_BITS-1:0]   fp,
	output logic [2*COORD_BITS-1:0]   sp,
	output logic                      match
);

	ampf_flags_t               flags_q;
	logic [2*COORD_BITS-1:0]   fp_q;
	logic [2*COORD_BITS-1:0]   sp_q;

	assign match = flags_q.valid & ((fp_q == new_fp) | (sp_q == new_sp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctrl.shift) begin
			flags_q <= nxt_flags;
		end else if (ctrl.load) begin
			if (sel) begin
				flags_q.valid <= 1'b1;
				flags_q.mark  <= ctrl.mark_new;
			end else if (match) begin
				flags_q.mark <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			fp_q <= nxt_fp;
			sp_q <= nxt_sp;
		end else if (ctrl.load && sel) begin
			fp_q <= new_fp;
			sp_q <= new_sp;
		end
	end

	assign flags = flags_q;
	assign fp    = fp_q;
	assign sp    = sp_q;

endmodule

// ----- hdl/ambiguous_match_pair_filter.sv -----
// Top level of the ambiguous match pair filter: cell chain, fill and drain control.
// Pairs are taken one per cycle into a chain of CAPACITY cells; each new pair is compared
// with every stored pair as it arrives, and matching pairs are marked ambiguous. Pairs past
// CAPACITY are dropped and flagged. After the pair marked final_pair, src_stall stays high
// while the chain shifts toward its head one cell per cycle, except while dst_stall holds the
// output register and a kept pair waits to leave. Kept pairs leave in input order, the last
// one with run_end; a list with no kept pairs gives one result with pair_valid low.
// No clearing pass is needed after reset.
module ambiguous_match_pair_filter import ampf_pkg::*; #(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  logic [COORD_BITS-1:0] first_x,
	input  logic [COORD_BITS-1:0] first_y,
	input  logic [COORD_BITS-1:0] second_x,
	input  logic [COORD_BITS-1:0] second_y,
	input  logic                  final_pair,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output logic [COORD_BITS-1:0] kept_first_x,
	output logic [COORD_BITS-1:0] kept_first_y,
	output logic [COORD_BITS-1:0] kept_second_x,
	output logic [COORD_BITS-1:0] kept_second_y,
	output logic                  pair_valid,
	output logic                  run_end,
	output logic                  overflowed
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned PW    = 2 * COORD_BITS;

	typedef enum logic {ST_FILL, ST_DRAIN} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic               pend_v_q;
	logic [PW-1:0]      pend_fp_q;
	logic [PW-1:0]      pend_sp_q;
	logic               dst_valid_q;
	logic [PW-1:0]      out_fp_q;
	logic [PW-1:0]      out_sp_q;
	logic               out_pv_q;
	logic               out_end_q;
	logic               out_ovf_q;

	ampf_flags_t        flags [CAPACITY];
	logic [PW-1:0]      fp_c  [CAPACITY];
	logic [PW-1:0]      sp_c  [CAPACITY];
	logic [CAPACITY-1:0] match_v;
	logic [CAPACITY-1:0] valid_v;

	ampf_ctrl_t         ctrl;
	logic [PW-1:0]      new_fp;
	logic [PW-1:0]      new_sp;
	logic               take;
	logic               room;
	logic               out_free;
	logic               head_keep;
	logic               emit_pend;
	logic               finish;

	assign new_fp    = {first_x, first_y};
	assign new_sp    = {second_x, second_y};
	assign src_stall = (state_q != ST_FILL);
	assign take      = src_valid & ~src_stall;
	assign room      = (cnt_q < CNT_W'(CAPACITY));
	assign out_free  = ~dst_valid_q | ~dst_stall;
	assign head_keep = flags[0].valid & ~flags[0].mark;
	assign emit_pend = (state_q == ST_DRAIN) & head_keep & pend_v_q & out_free;
	assign finish    = (state_q == ST_DRAIN) & ~flags[0].valid & out_free;

	always_comb begin
		ctrl.load     = take & room;
		ctrl.mark_new = |match_v;
		ctrl.shift    = (state_q == ST_DRAIN) & flags[0].valid &
				(~head_keep | ~pend_v_q | out_free);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ampf_flags_t   nf;
		logic [PW-1:0] nfp;
		logic [PW-1:0] nsp;

		if (i == CAPACITY - 1) begin : g_tail
			assign nf  = '0;
			assign nfp = '0;
			assign nsp = '0;
		end else begin : g_link
			assign nf  = flags[i+1];
			assign nfp = fp_c[i+1];
			assign nsp = sp_c[i+1];
		end

		ampf_cell #(
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.sel       (cnt_q == CNT_W'(i)),
			.new_fp    (new_fp),
			.new_sp    (new_sp),
			.nxt_flags (nf),
			.nxt_fp    (nfp),
			.nxt_sp    (nsp),
			.flags     (flags[i]),
			.fp        (fp_c[i]),
			.sp        (sp_c[i]),
			.match     (match_v[i])
		);

		assign valid_v[i] = flags[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			if (emit_pend || finish) begin
				dst_valid_q <= 1'b1;
			end else if (dst_valid_q && !dst_stall) begin
				dst_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (take) begin
						if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_pair) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (ctrl.shift && head_keep) begin
						pend_v_q <= 1'b1;
					end
					if (finish) begin
						state_q  <= ST_FILL;
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift && head_keep) begin
			pend_fp_q <= fp_c[0];
			pend_sp_q <= sp_c[0];
		end
		if (emit_pend || finish) begin
			out_fp_q  <= pend_v_q ? pend_fp_q : '0;
			out_sp_q  <= pend_v_q ? pend_sp_q : '0;
			out_pv_q  <= pend_v_q;
			out_end_q <= finish;
			out_ovf_q <= ovf_q;
		end
	end

	assign dst_valid     = dst_valid_q;
	assign kept_first_x  = out_fp_q[PW-1:COORD_BITS];
	assign kept_first_y  = out_fp_q[COORD_BITS-1:0];
	assign kept_second_x = out_sp_q[PW-1:COORD_BITS];
	assign kept_second_y = out_sp_q[COORD_BITS-1:0];
	assign pair_valid    = out_pv_q;
	assign run_end       = out_end_q;
	assign overflowed    = out_ovf_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("pair count beyond capacity");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_v >> 1) & ~valid_v) == '0)
		else $error("occupied cells not packed toward the head");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> $countones(valid_v) == int'(cnt_q))
		else $error("occupied cells disagree with pair count");

	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> cnt_q == '0 && !ovf_q && !pend_v_q && state_q == ST_FILL)
		else $error("list state not cleared after drain");

endmodule
